// ----- hdl/tcs_pkg.sv -----
`default_nettype none
package tcs_pkg;

    // Block parameters
    localparam int ORDER_SLOTS = 1024;
    localparam int TRI_LIMIT   = 1024;
    localparam int TEX_SLOTS   = 64;

    // Depth bucket: ((za + zb + zc) * (ORDER_SLOTS / 3)) >> BUCKET_SHIFT
    localparam int BUCKET_SHIFT = 12;
    localparam int BUCKET_SCALE = ORDER_SLOTS / 3;
    localparam int DEPTH_SUM_W  = 18;
    localparam int SCALE_W      = $clog2(BUCKET_SCALE + 1);
    localparam int PROD_W       = DEPTH_SUM_W + SCALE_W;
    localparam int BUCKET_RAW_W = PROD_W - BUCKET_SHIFT;
    localparam int BUCKET_W     = 10;

    localparam int CNT_W   = $clog2(TRI_LIMIT + 1);
    localparam int SLOT_AW = (TEX_SLOTS > 1) ? $clog2(TEX_SLOTS) : 1;
    localparam int SLOT_W  = 64;

    // Screen box limits
    localparam logic signed [15:0] COORD_LO = -16'sd512;
    localparam logic signed [15:0] COORD_HI = 16'sd512;

    // Opcodes
    localparam logic [1:0] OP_TRIANGLE    = 2'd0;
    localparam logic [1:0] OP_SLOT_WRITE  = 2'd1;
    localparam logic [1:0] OP_CLEAR_COUNT = 2'd2;

    // Config register indexes
    localparam logic [1:0] CFG_TEXTURE_BASE  = 2'd0;
    localparam logic [1:0] CFG_TEXTURE_COUNT = 2'd1;
    localparam logic [1:0] CFG_SLOT_COUNT    = 2'd2;

    // Stage 1 contents, front end to back end
    typedef struct packed {
        logic                     is_tri;
        logic                     is_clear;
        logic                     early_cull;   // zero depth or off the screen box
        logic signed [33:0]       prod_a;       // (xb - xa) * (yc - ya)
        logic signed [33:0]       prod_b;       // (xc - xa) * (yb - ya)
        logic [BUCKET_RAW_W-1:0]  bucket_raw;
        logic                     tex_valid;
        logic [31:0]              point_a;
        logic [31:0]              point_b;
        logic [31:0]              point_c;
        logic [15:0]              uv_a;
        logic [15:0]              uv_b;
        logic [15:0]              uv_c;
    } stage_t;

    // One emitted triangle
    typedef struct packed {
        logic [31:0]          point_a;
        logic [31:0]          point_b;
        logic [31:0]          point_c;
        logic [15:0]          mapped_uv_a;
        logic [15:0]          mapped_uv_b;
        logic [15:0]          mapped_uv_c;
        logic [15:0]          texture_page;
        logic [15:0]          palette_index;
        logic [BUCKET_W-1:0]  depth_bucket;
        logic                 textured;
    } result_t;

endpackage
`default_nettype wire

// ----- hdl/tcs_ram.sv -----
`default_nettype none
module tcs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ----- hdl/tcs_front.sv -----
`default_nettype none
module tcs_front
    import tcs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               advance,
    input  wire logic               accept,
    input  wire logic [1:0]         opcode,
    input  wire logic [47:0]        vertex_a,
    input  wire logic [47:0]        vertex_b,
    input  wire logic [47:0]        vertex_c,
    input  wire logic [15:0]        texcoord_a,
    input  wire logic [15:0]        texcoord_b,
    input  wire logic [15:0]        texcoord_c,
    input  wire logic [7:0]         texture_id,
    input  wire logic [5:0]         slot_index,
    input  wire logic [63:0]        slot_word,
    input  wire logic [7:0]         texture_base,
    input  wire logic [7:0]         texture_count,
    input  wire logic [6:0]         slot_count,
    output logic                    ram_we,
    output logic [SLOT_AW-1:0]      ram_waddr,
    output logic [SLOT_W-1:0]       ram_wdata,
    output logic                    ram_re,
    output logic [SLOT_AW-1:0]      ram_raddr,
    output logic                    s1_valid,
    output stage_t                  s1
);

    logic signed [15:0] xa, ya, xb, yb, xc, yc;
    logic [15:0]        za, zb, zc;
    logic signed [16:0] dx1, dy1, dx2, dy2;
    logic               in_box;
    logic [DEPTH_SUM_W-1:0] depth_sum;
    logic [PROD_W-1:0]  bucket_prod;
    logic [8:0]         slot_sel;
    logic [8:0]         wr_sel;
    logic               is_tri, is_clear;
    logic               s1_valid_reg;
    stage_t             s1_reg, s1_next;

    assign xa = signed'(vertex_a[15:0]);
    assign ya = signed'(vertex_a[31:16]);
    assign za = vertex_a[47:32];
    assign xb = signed'(vertex_b[15:0]);
    assign yb = signed'(vertex_b[31:16]);
    assign zb = vertex_b[47:32];
    assign xc = signed'(vertex_c[15:0]);
    assign yc = signed'(vertex_c[31:16]);
    assign zc = vertex_c[47:32];

    assign dx1 = 17'(xb) - 17'(xa);
    assign dy1 = 17'(yb) - 17'(ya);
    assign dx2 = 17'(xc) - 17'(xa);
    assign dy2 = 17'(yc) - 17'(ya);

    assign in_box = (xa >= COORD_LO) && (xa <= COORD_HI) && (ya >= COORD_LO) && (ya <= COORD_HI)
                 && (xb >= COORD_LO) && (xb <= COORD_HI) && (yb >= COORD_LO) && (yb <= COORD_HI)
                 && (xc >= COORD_LO) && (xc <= COORD_HI) && (yc >= COORD_LO) && (yc <= COORD_HI);

    assign depth_sum   = DEPTH_SUM_W'(za) + DEPTH_SUM_W'(zb) + DEPTH_SUM_W'(zc);
    assign bucket_prod = PROD_W'(depth_sum) * PROD_W'(BUCKET_SCALE);

    assign slot_sel = {1'b0, texture_base} + {1'b0, texture_id};
    assign wr_sel   = {3'b000, slot_index};

    assign is_tri   = (opcode == OP_TRIANGLE);
    assign is_clear = (opcode == OP_CLEAR_COUNT);

    // slot table access: writes land at acceptance, triangle reads return next cycle
    assign ram_we    = accept && (opcode == OP_SLOT_WRITE) && (wr_sel < 9'(TEX_SLOTS));
    assign ram_waddr = SLOT_AW'(wr_sel);
    assign ram_wdata = slot_word;
    assign ram_re    = accept && is_tri;
    assign ram_raddr = SLOT_AW'(slot_sel);

    always_comb
    begin
        s1_next.is_tri     = is_tri;
        s1_next.is_clear   = is_clear;
        s1_next.early_cull = (za == 16'd0) || (zb == 16'd0) || (zc == 16'd0) || !in_box;
        s1_next.prod_a     = dx1 * dy2;
        s1_next.prod_b     = dx2 * dy1;
        s1_next.bucket_raw = bucket_prod[PROD_W-1:BUCKET_SHIFT];
        s1_next.tex_valid  = (texture_id < texture_count)
                          && (slot_sel < {2'b00, slot_count})
                          && (slot_sel < 9'(TEX_SLOTS));
        s1_next.point_a    = vertex_a[31:0];
        s1_next.point_b    = vertex_b[31:0];
        s1_next.point_c    = vertex_c[31:0];
        s1_next.uv_a       = texcoord_a;
        s1_next.uv_b       = texcoord_b;
        s1_next.uv_c       = texcoord_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= accept && (is_tri || is_clear);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_reg <= s1_next;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1       = s1_reg;

endmodule
`default_nettype wire

// ----- hdl/tcs_back.sv -----
`default_nettype none
module tcs_back
    import tcs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s1_valid,
    input  wire stage_t             s1,
    input  wire logic [SLOT_W-1:0]  slot,
    input  wire logic               out_ready,
    output logic                    advance,
    output logic                    out_valid,
    output result_t                 out_data
);

    logic [CNT_W-1:0]   count_reg, count_next;
    logic               out_valid_reg;
    result_t            out_data_reg, out_data_next;
    logic [34:0]        cross_val;
    logic [31:0]        bucket_wide;
    logic               bucket_ok, count_ok, keep;

    function automatic logic [15:0] remap(input logic [15:0] uv, input logic [SLOT_W-1:0] s);
        logic [7:0] u;
        logic [7:0] v;
        u = (uv[7:0] & s[7:0]) + s[23:16];
        v = (uv[15:8] & s[15:8]) + s[31:24];
        return {v, u};
    endfunction

    assign advance = !out_valid_reg || out_ready;

    // negative cross product means the triangle faces the viewer
    assign cross_val   = {s1.prod_a[33], s1.prod_a} - {s1.prod_b[33], s1.prod_b};
    assign bucket_wide = 32'(s1.bucket_raw);
    assign bucket_ok   = (bucket_wide != 32'd0) && (bucket_wide < 32'(ORDER_SLOTS));
    assign count_ok    = count_reg < CNT_W'(TRI_LIMIT);
    assign keep        = s1_valid && s1.is_tri && !s1.early_cull && cross_val[34]
                      && bucket_ok && count_ok;

    always_comb
    begin
        out_data_next.point_a      = s1.point_a;
        out_data_next.point_b      = s1.point_b;
        out_data_next.point_c      = s1.point_c;
        out_data_next.depth_bucket = bucket_wide[BUCKET_W-1:0];
        out_data_next.textured     = s1.tex_valid;
        if (s1.tex_valid)
        begin
            out_data_next.mapped_uv_a   = remap(s1.uv_a, slot);
            out_data_next.mapped_uv_b   = remap(s1.uv_b, slot);
            out_data_next.mapped_uv_c   = remap(s1.uv_c, slot);
            out_data_next.texture_page  = slot[47:32];
            out_data_next.palette_index = slot[63:48];
        end
        else
        begin
            out_data_next.mapped_uv_a   = 16'd0;
            out_data_next.mapped_uv_b   = 16'd0;
            out_data_next.mapped_uv_c   = 16'd0;
            out_data_next.texture_page  = 16'd0;
            out_data_next.palette_index = 16'd0;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (advance && s1_valid && s1.is_clear)
        begin
            count_next = '0;
        end
        else if (advance && keep)
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (advance)
            begin
                out_valid_reg <= keep;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && keep)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire

// ----- hdl/triangle_cull_and_setup.sv -----
`default_nettype none
// Triangle cull and setup. One beat in, at most one beat out: an opcode-0
// beat carries a projected triangle, which is dropped (zero depth, facing
// away, off the -512..512 box, depth bucket outside 1..ORDER_SLOTS-1, or
// emitted count at TRI_LIMIT) or comes out with its points, ordering-table
// bucket and slot-remapped texture coordinates. Opcode 1 loads one slot of
// the texture table, opcode 2 clears the emitted count; neither emits.
// Throughput is one beat per clock while m_tready stays high; s_tready drops
// only while the output register holds a beat that m_tready does not take.
// Accepting a triangle loads stage 1 (edge products, depth product, slot
// table read); when the pipe next advances, the output register is loaded,
// which finishes the cull and the remap and offers the result beat. The slot
// table is a 64-bit-wide memory with one write and one registered read port;
// a slot write takes effect for every later beat. The table is not cleared
// after reset: load a slot before a triangle uses it. Config registers must
// be written only while the block is idle; the block does not enforce it.
module triangle_cull_and_setup
    import tcs_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,

    // config write port: 0 texture_base, 1 texture_count, 2 slot_count
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [7:0]   cfg_data,

    input  wire logic         s_tvalid,
    output logic              s_tready,
    // vertex_a, vertex_b, vertex_c, texcoord_a, texcoord_b, texcoord_c,
    // texture_id, slot_index, slot_word, 2 bits zero fill
    input  wire logic [271:0] s_tdata,
    // opcode
    input  wire logic [1:0]   s_tuser,

    output logic              m_tvalid,
    input  wire logic         m_tready,
    // point_a, point_b, point_c, mapped_uv_a, mapped_uv_b, mapped_uv_c,
    // texture_page, palette_index, depth_bucket, 6 bits zero fill
    output logic [191:0]      m_tdata,
    // textured
    output logic [0:0]        m_tuser
);

    logic [7:0]          texture_base_reg;
    logic [7:0]          texture_count_reg;
    logic [6:0]          slot_count_reg;

    logic                advance;
    logic                accept;
    logic                ram_we, ram_re;
    logic [SLOT_AW-1:0]  ram_waddr, ram_raddr;
    logic [SLOT_W-1:0]   ram_wdata, ram_rdata;
    logic                s1_valid;
    stage_t              s1;
    result_t             res;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            texture_base_reg  <= 8'd0;
            texture_count_reg <= 8'd0;
            slot_count_reg    <= 7'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TEXTURE_BASE:  texture_base_reg  <= cfg_data;
                CFG_TEXTURE_COUNT: texture_count_reg <= cfg_data;
                CFG_SLOT_COUNT:    slot_count_reg    <= cfg_data[6:0];
                default:           ;   // no register at this index
            endcase
        end
    end

    // input is taken whenever the pipe moves; the output register decouples
    assign s_tready = advance;
    assign accept   = s_tvalid && advance;

    tcs_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .accept        (accept),
        .opcode        (s_tuser),
        .vertex_a      (s_tdata[47:0]),
        .vertex_b      (s_tdata[95:48]),
        .vertex_c      (s_tdata[143:96]),
        .texcoord_a    (s_tdata[159:144]),
        .texcoord_b    (s_tdata[175:160]),
        .texcoord_c    (s_tdata[191:176]),
        .texture_id    (s_tdata[199:192]),
        .slot_index    (s_tdata[205:200]),
        .slot_word     (s_tdata[269:206]),
        .texture_base  (texture_base_reg),
        .texture_count (texture_count_reg),
        .slot_count    (slot_count_reg),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .ram_re        (ram_re),
        .ram_raddr     (ram_raddr),
        .s1_valid      (s1_valid),
        .s1            (s1)
    );

    // texture slot table; read data holds while the pipe is stalled
    tcs_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (TEX_SLOTS),
        .AW    (SLOT_AW)
    ) u_slot_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tcs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1_valid  (s1_valid),
        .s1        (s1),
        .slot      (ram_rdata),
        .out_ready (m_tready),
        .advance   (advance),
        .out_valid (m_tvalid),
        .out_data  (res)
    );

    assign m_tdata = {6'd0, res.depth_bucket, res.palette_index, res.texture_page,
                      res.mapped_uv_c, res.mapped_uv_b, res.mapped_uv_a,
                      res.point_c, res.point_b, res.point_a};
    assign m_tuser = res.textured;

endmodule
`default_nettype wire
